FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers used by the decoder top level
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define X86FD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define X86FD_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define X86FD_ASSERT(lbl, clk, rstn, prop, msg)
`define X86FD_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

FILE: rtl/core/x86fd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86fd_pkg
// types, constants and opcode helpers of the 8086 field decoder
// ----------------------------------------------------------------------------
package x86fd_pkg;

  localparam int unsigned AddrBitsDefault  = 16;
  localparam int unsigned FifoDepthDefault = 4;

  localparam logic [2:0] RmDirect = 3'b110;

  typedef enum logic [2:0] {
    CLS_ARITH     = 3'd0,
    CLS_MOV_IREG  = 3'd1,
    CLS_MOV_RM    = 3'd2,
    CLS_ARITH_IRM = 3'd3,
    CLS_MOV_IRM   = 3'd4,
    CLS_JUMP      = 3'd5,
    CLS_UNKNOWN   = 3'd6
  } op_class_e;

  // one finished instruction as collected by the front end
  typedef struct packed {
    logic [15:0] start_addr;
    logic [7:0]  opcode;
    logic [7:0]  modrm;
    logic [15:0] disp;
    logic [15:0] data;
    logic [2:0]  len;
  } instr_rec_t;

  function automatic op_class_e classify(input logic [7:0] op);
    op_class_e c;
    if (op[7:6] == 2'b00) begin
      c = (op[2:1] == 2'b11) ? CLS_UNKNOWN : CLS_ARITH;
    end else if (op[7:4] == 4'hB) begin
      c = CLS_MOV_IREG;
    end else if (op[7:2] == 6'h22) begin
      c = CLS_MOV_RM;
    end else if (op[7:2] == 6'h20) begin
      c = CLS_ARITH_IRM;
    end else if (op[7:1] == 7'h63) begin
      c = CLS_MOV_IRM;
    end else if (op[7:4] == 4'h7 || op[7:2] == 6'h38) begin
      c = CLS_JUMP;
    end else begin
      c = CLS_UNKNOWN;
    end
    return c;
  endfunction

  function automatic logic has_modrm(input logic [7:0] op);
    logic r;
    unique case (classify(op))
      CLS_ARITH:                              r = ~op[2];
      CLS_MOV_RM, CLS_ARITH_IRM, CLS_MOV_IRM: r = 1'b1;
      default:                                r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] disp_count(input logic [7:0] modrm);
    logic [1:0] n;
    unique case (modrm[7:6])
      2'b00:   n = (modrm[2:0] == RmDirect) ? 2'd2 : 2'd0;
      2'b01:   n = 2'd1;
      2'b10:   n = 2'd2;
      default: n = 2'd0;
    endcase
    return n;
  endfunction

  function automatic logic [1:0] data_count(input logic [7:0] op);
    logic [1:0] n;
    unique case (classify(op))
      CLS_ARITH:     n = op[2] ? {1'b0, 1'b1} + {1'b0, op[0]} : 2'd0;
      CLS_MOV_IREG:  n = op[3] ? 2'd2 : 2'd1;
      CLS_ARITH_IRM: n = (op[0] && !op[1]) ? 2'd2 : 2'd1;
      CLS_MOV_IRM:   n = {1'b0, 1'b1} + {1'b0, op[0]};
      CLS_JUMP:      n = 2'd1;
      default:       n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

FILE: rtl/core/x86fd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86fd_front
// takes code bytes, tracks the byte position and gathers instruction fields
// ----------------------------------------------------------------------------
module x86fd_front import x86fd_pkg::*; #(
  parameter int unsigned ADDRESS_BITS = AddrBitsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] code_byte_i,
  output logic       rec_push_o,
  output instr_rec_t rec_o
);

  logic [2:0]              pos_q, pos_d;
  logic [7:0]              op_q, op_d;
  logic [7:0]              modrm_q, modrm_d;
  logic [15:0]             disp_q, disp_d;
  logic [15:0]             data_q, data_d;
  logic [ADDRESS_BITS-1:0] addr_q, start_q, start_d;
  logic [ADDRESS_BITS+15:0] start_ext;
  logic                    mr, done;
  logic [2:0]              off, idx, idx2, dn, len;

  always_comb begin
    op_d    = (pos_q == 3'd0) ? code_byte_i : op_q;
    modrm_d = (pos_q == 3'd0) ? 8'd0 : modrm_q;
    disp_d  = (pos_q == 3'd0) ? 16'd0 : disp_q;
    data_d  = (pos_q == 3'd0) ? 16'd0 : data_q;
    start_d = (pos_q == 3'd0) ? addr_q : start_q;
    mr      = has_modrm(op_d);
    off     = mr ? 3'd2 : 3'd1;
    idx     = pos_q - off;
    idx2    = 3'd0;
    dn      = 3'd0;
    if (pos_q == 3'd1 && mr) begin
      modrm_d = code_byte_i;
    end else if (pos_q >= off) begin
      dn = mr ? {1'b0, disp_count(modrm_d)} : 3'd0;
      if (idx < dn) begin
        if (idx == 3'd0) disp_d[7:0] = code_byte_i;
        else             disp_d[15:8] = code_byte_i;
      end else begin
        idx2 = idx - dn;
        if (idx2 == 3'd0) data_d[7:0] = code_byte_i;
        else              data_d[15:8] = code_byte_i;
      end
    end
    if (classify(op_d) == CLS_UNKNOWN) begin
      len = 3'd1;
    end else if (mr && pos_q == 3'd0) begin
      len = 3'd2;
    end else begin
      len = off + (mr ? {1'b0, disp_count(modrm_d)} : 3'd0) + {1'b0, data_count(op_d)};
    end
    done = ({1'b0, pos_q} + 4'd1) >= {1'b0, len};
    pos_d = done ? 3'd0 : pos_q + 3'd1;
  end

  assign start_ext = {16'd0, start_d};

  assign rec_push_o       = accept_i & done;
  assign rec_o.start_addr = start_ext[15:0];
  assign rec_o.opcode     = op_d;
  assign rec_o.modrm      = modrm_d;
  assign rec_o.disp       = disp_d;
  assign rec_o.data       = data_d;
  assign rec_o.len        = len;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= 3'd0;
      op_q    <= 8'd0;
      modrm_q <= 8'd0;
      disp_q  <= 16'd0;
      data_q  <= 16'd0;
      addr_q  <= '0;
      start_q <= '0;
    end else if (accept_i) begin
      pos_q   <= pos_d;
      op_q    <= op_d;
      modrm_q <= modrm_d;
      disp_q  <= disp_d;
      data_q  <= data_d;
      addr_q  <= addr_q + 1'b1;
      start_q <= start_d;
    end
  end

endmodule

FILE: rtl/core/x86fd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86fd_fifo
// short record queue between the front end and the back end
// ----------------------------------------------------------------------------
module x86fd_fifo import x86fd_pkg::*; #(
  parameter int unsigned DEPTH = FifoDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  instr_rec_t wdata_i,
  output logic       full_o,
  input  logic       pop_i,
  output instr_rec_t rdata_o,
  output logic       empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  instr_rec_t           mem_q [DEPTH];
  logic [PtrW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]      cnt_q;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/x86fd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86fd_back
// turns a collected record into decoded fields and holds the output register
// ----------------------------------------------------------------------------
module x86fd_back import x86fd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rec_empty_i,
  input  instr_rec_t         rec_i,
  output logic               rec_pop_o,
  input  logic               pop_i,
  output logic               empty_o,
  output logic [15:0]        start_address_o,
  output logic [2:0]         op_class_o,
  output logic [2:0]         op_mid_o,
  output logic [3:0]         flag_bits_o,
  output logic [1:0]         mode_o,
  output logic [2:0]         reg_field_o,
  output logic [2:0]         rm_field_o,
  output logic signed [15:0] displacement_o,
  output logic [15:0]        immediate_o,
  output logic signed [7:0]  jump_offset_o,
  output logic [2:0]         length_o,
  output logic [7:0]         first_byte_o
);

  logic        valid_q;
  logic        load;
  op_class_e   cls;
  logic        mr;
  logic [1:0]  dn;
  logic [2:0]  mid, reg_f, rm_f;
  logic [3:0]  flags;
  logic [1:0]  md;
  logic [15:0] disp, imm;
  logic [7:0]  jo, op;

  assign load      = ~rec_empty_i & (~valid_q | pop_i);
  assign rec_pop_o = load;
  assign empty_o   = ~valid_q;

  always_comb begin
    op    = rec_i.opcode;
    cls   = classify(op);
    mr    = has_modrm(op);
    dn    = mr ? disp_count(rec_i.modrm) : 2'd0;
    mid   = 3'd0;
    flags = 4'd0;
    md    = 2'd0;
    reg_f = 3'd0;
    rm_f  = 3'd0;
    disp  = 16'd0;
    imm   = 16'd0;
    jo    = 8'd0;
    if (mr) begin
      md    = rec_i.modrm[7:6];
      reg_f = rec_i.modrm[5:3];
      rm_f  = rec_i.modrm[2:0];
      if (dn == 2'd1) begin
        disp = {{8{rec_i.disp[7]}}, rec_i.disp[7:0]};
      end else if (dn == 2'd2) begin
        disp = rec_i.disp;
      end
    end
    unique case (cls)
      CLS_ARITH: begin
        mid   = op[5:3];
        flags = {op[2], 1'b0, op[1], op[0]};
        if (op[2]) imm = rec_i.data;
      end
      CLS_MOV_IREG: begin
        flags = {3'b000, op[3]};
        reg_f = op[2:0];
        imm   = rec_i.data;
      end
      CLS_MOV_RM: begin
        flags = {2'b00, op[1], op[0]};
      end
      CLS_ARITH_IRM: begin
        mid   = reg_f;
        flags = {1'b0, op[1], 1'b0, op[0]};
        imm   = rec_i.data;
      end
      CLS_MOV_IRM: begin
        flags = {3'b000, op[0]};
        imm   = rec_i.data;
      end
      CLS_JUMP: begin
        jo = rec_i.data[7:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (pop_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      start_address_o <= rec_i.start_addr;
      op_class_o      <= cls;
      op_mid_o        <= mid;
      flag_bits_o     <= flags;
      mode_o          <= md;
      reg_field_o     <= reg_f;
      rm_field_o      <= rm_f;
      displacement_o  <= disp;
      immediate_o     <= imm;
      jump_offset_o   <= jo;
      length_o        <= rec_i.len;
      first_byte_o    <= op;
    end
  end

endmodule

FILE: rtl/core/x86_16_instruction_field_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86_16_instruction_field_decoder_unit
// 8086 code byte stream to decoded instruction records
// ----------------------------------------------------------------------------
// input channel: one code byte per transaction, taken when push is high
// and full is low. bytes form a continuous instruction stream.
// output channel: one record per complete instruction, shown while empty
// is low and taken when pop is high. unknown opcodes give a record of
// length 1.
// throughput: one byte per cycle while full is low. the front end updates
// few registers per byte; the back end formats one record per cycle while
// the output register is empty or popped, taking it from the record queue.
// output path: the record of an instruction is written to the queue at the
// edge that takes its last byte, then loaded into the output register.
// stall: when pop stays low the output register holds its record and the
// record queue fills; full rises only once the queue is full.
// reset: byte position and address counter go to zero, no record is held.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module x86_16_instruction_field_decoder_unit import x86fd_pkg::*; #(
  parameter int unsigned ADDRESS_BITS = AddrBitsDefault,
  parameter int unsigned FIFO_DEPTH   = FifoDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         code_byte_i,
  output logic               empty,
  input  logic               pop,
  output logic [15:0]        start_address_o,
  output logic [2:0]         op_class_o,
  output logic [2:0]         op_mid_o,
  output logic [3:0]         flag_bits_o,
  output logic [1:0]         mode_o,
  output logic [2:0]         reg_field_o,
  output logic [2:0]         rm_field_o,
  output logic signed [15:0] displacement_o,
  output logic [15:0]        immediate_o,
  output logic signed [7:0]  jump_offset_o,
  output logic [2:0]         length_o,
  output logic [7:0]         first_byte_o
);

  logic       accept;
  logic       rec_push, rec_pop, rec_empty;
  instr_rec_t rec_w, rec_r;

  assign accept = push & ~full;

  x86fd_front #(
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .code_byte_i(code_byte_i),
    .rec_push_o (rec_push),
    .rec_o      (rec_w)
  );

  x86fd_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (rec_push),
    .wdata_i(rec_w),
    .full_o (full),
    .pop_i  (rec_pop),
    .rdata_o(rec_r),
    .empty_o(rec_empty)
  );

  x86fd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rec_empty_i    (rec_empty),
    .rec_i          (rec_r),
    .rec_pop_o      (rec_pop),
    .pop_i          (pop),
    .empty_o        (empty),
    .start_address_o(start_address_o),
    .op_class_o     (op_class_o),
    .op_mid_o       (op_mid_o),
    .flag_bits_o    (flag_bits_o),
    .mode_o         (mode_o),
    .reg_field_o    (reg_field_o),
    .rm_field_o     (rm_field_o),
    .displacement_o (displacement_o),
    .immediate_o    (immediate_o),
    .jump_offset_o  (jump_offset_o),
    .length_o       (length_o),
    .first_byte_o   (first_byte_o)
  );

  `X86FD_ASSERT(a_full_has_out, clk_i, rst_ni, full |-> !empty, "queue full with idle output")
  `X86FD_ASSERT(a_len_range, clk_i, rst_ni, !empty |-> (length_o != 3'd0 && length_o <= 3'd6), "bad length")
  `X86FD_ASSERT(a_unknown_len, clk_i, rst_ni, (!empty && op_class_o == CLS_UNKNOWN) |-> length_o == 3'd1, "unknown opcode length")
  `X86FD_NEVER(a_pop_empty_q, clk_i, rst_ni, rec_pop && rec_empty, "record queue read while empty")

endmodule
